// File: hw/rtl/wtr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtr_pkg: shared types and constants for the world-to-radar point transform
// Word layouts, register indexes, fixed-point widths and the quarter-wave
// sine table.
// ----------------------------------------------------------------------------
package wtr_pkg;

   // Table and angle resolution
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int ANGLE_BITS       = 16;

   // Field widths
   localparam int COORD_W      = 20;
   localparam int YAW_W        = 16;
   localparam int YAW_PAD      = 24;
   localparam int ZOOM_W       = 16;
   localparam int WIN_W        = 13;
   localparam int ORIGIN_W     = 32;
   localparam int ORIGIN_HALF_W = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // Pipeline depth: stages 1..NUM_STAGES
   localparam int NUM_STAGES = 10;

   // Sine table: unsigned Q1.15 magnitudes, signed after the quadrant fold
   localparam int SINE_W     = 17;
   localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int IDX_PROD_W = ANGLE_BITS - 1 + SINE_IDX_W;
   localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

   // Rotation datapath widths
   localparam int OFFSET_W = COORD_W + 1;
   localparam int PROD_W   = OFFSET_W + SINE_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int SCALED_W = SUM_W + ZOOM_W + 1;

   // Scale: divide by 20000 * 2^15 = 625 * 2^20, rounded half away from zero
   localparam longint unsigned SCALE_DIV  = 64'd20000 * (64'd1 << 15);
   localparam longint unsigned ROUND_HALF = SCALE_DIV / 2;
   localparam int ROUND_SHIFT = 20;
   localparam int SHIFT_W     = SCALED_W + 1 - ROUND_SHIFT;
   localparam int QUOT_DIV    = int'(SCALE_DIV >> ROUND_SHIFT);
   // Magnitudes at or above 2^21 all give the same clamped or saturated point
   localparam int QUOT_LIMIT_BITS = 21;
   localparam int NUM_W       = 31;
   localparam longint unsigned NUM_SAT = longint'(QUOT_DIV) << QUOT_LIMIT_BITS;
   localparam int RECIP_SHIFT = 41;
   localparam int RECIP_W     = 32;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / QUOT_DIV;
   localparam int PRODQ_W     = NUM_W + RECIP_W;
   localparam int QE_W        = QUOT_LIMIT_BITS + 1;
   localparam int QUOT_W      = QE_W + 1;

   // Placement widths and bounds
   localparam int PLACE_W     = 24;
   localparam int FINAL_W     = PLACE_W + 1;
   localparam int EDGE_LOW_Q4 = 80;
   localparam int OUT_MAX     = 524287;
   localparam int OUT_MIN     = -524288;

   // Register reset values
   localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(1000);
   localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(200);

   typedef logic signed [SINE_W-1:0] sine_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EYE_X,
      CSR_EYE_Y,
      CSR_VIEW_YAW,
      CSR_ZOOM_MILLI,
      CSR_WINDOW_W,
      CSR_WINDOW_H,
      CSR_WINDOW_ORIGIN,
      CSR_CLAMP_ENABLE
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      clamp_request;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
   } rsp_word_type;

   typedef logic [SINE_TABLE_DEPTH:0][SINE_W-1:0] sine_table_type;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Taylor series of sin in Q2.30, rounded half up to Q1.15
   function automatic sine_table_type build_sine_table();
      sine_table_type  tab;
      longint unsigned x;
      longint unsigned t;
      longint          sum;
      longint          q;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x   = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         t   = x;
         sum = longint'(x);
         for (int n = 1; n <= 5; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (n)
               1:       t = t / 6;
               2:       t = t / 20;
               3:       t = t / 42;
               4:       t = t / 72;
               default: t = t / 110;
            endcase
            if ((n & 1) == 1) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (sum + (64'sd1 <<< 14)) >>> 15;
         if (q > 32768) begin
            q = 32768;
         end
         tab[k] = SINE_W'(q);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage
`default_nettype wire

// File: hw/rtl/wtr_trig.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtr_trig: sine and cosine of the view yaw less a quarter turn
// Folds the angle into one quadrant, reads the quarter-wave table and
// registers both values. Change the yaw only with the pipeline empty; not enforced.
// ----------------------------------------------------------------------------
module wtr_trig
   import wtr_pkg::*;
(
   input  logic             clock,
   input  logic [YAW_W-1:0] view_yaw,
   output sine_type         sin_val,
   output sine_type         cos_val
);

   logic [ANGLE_BITS-1:0] ang_c;
   logic [ANGLE_BITS-1:0] ang_s;
   sine_type              sin_ff;
   sine_type              cos_ff;
   sine_type              sin_in;
   sine_type              cos_in;

   function automatic sine_type sine_lookup(input logic [ANGLE_BITS-1:0] ang);
      logic [1:0]            quad;
      logic [ANGLE_BITS-2:0] frac;
      logic [IDX_PROD_W-1:0] scaled;
      logic [SINE_IDX_W-1:0] idx;
      sine_type              mag;
      quad = ang[ANGLE_BITS-1 -: 2];
      frac = {1'b0, ang[ANGLE_BITS-3:0]};
      // mirror odd quadrants
      if (quad[0]) begin
         frac = (ANGLE_BITS-1)'(ANGLE_QUARTER) - frac;
      end
      scaled = IDX_PROD_W'(frac) * IDX_PROD_W'(SINE_TABLE_DEPTH);
      idx    = SINE_IDX_W'(scaled >> (ANGLE_BITS - 2));
      mag    = SINE_TABLE[idx];
      return quad[1] ? -mag : mag;
   endfunction

   always_comb begin
      ang_c  = ANGLE_BITS'({view_yaw, {YAW_PAD{1'b0}}} >> (YAW_W + YAW_PAD - ANGLE_BITS));
      ang_s  = ang_c - ANGLE_QUARTER;
      sin_in = sine_lookup(ang_s);
      cos_in = sine_lookup(ang_c);
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule
`default_nettype wire

// File: hw/rtl/wtr_rotate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtr_rotate: pipeline stages 1 to 4
// Captures the word, forms the offset from the eye, takes the four
// products with sine and cosine and sums them into the rotated offset.
// ----------------------------------------------------------------------------
module wtr_rotate
   import wtr_pkg::*;
(
   input  logic                      clock,
   input  logic [3:0]                stage_en,
   input  req_word_type              in_word,
   input  logic signed [COORD_W-1:0] eye_x,
   input  logic signed [COORD_W-1:0] eye_y,
   input  sine_type                  sin_val,
   input  sine_type                  cos_val,
   output logic signed [SUM_W-1:0]   rot_x,
   output logic signed [SUM_W-1:0]   rot_y,
   output logic                      clamp_request
);

   req_word_type               word_ff;
   logic signed [OFFSET_W-1:0] dx_ff;
   logic signed [OFFSET_W-1:0] dy_ff;
   logic signed [OFFSET_W-1:0] dx_in;
   logic signed [OFFSET_W-1:0] dy_in;
   logic                       clamp2_ff;
   logic                       clamp3_ff;
   logic                       clamp4_ff;
   logic signed [PROD_W-1:0]   xc_ff;
   logic signed [PROD_W-1:0]   ys_ff;
   logic signed [PROD_W-1:0]   xs_ff;
   logic signed [PROD_W-1:0]   yc_ff;
   logic signed [PROD_W-1:0]   xc_in;
   logic signed [PROD_W-1:0]   ys_in;
   logic signed [PROD_W-1:0]   xs_in;
   logic signed [PROD_W-1:0]   yc_in;
   logic signed [SUM_W-1:0]    rot_x_ff;
   logic signed [SUM_W-1:0]    rot_y_ff;
   logic signed [SUM_W-1:0]    rot_x_in;
   logic signed [SUM_W-1:0]    rot_y_in;

   always_comb begin
      // y difference runs the other way
      dx_in    = OFFSET_W'(word_ff.point_x) - OFFSET_W'(eye_x);
      dy_in    = OFFSET_W'(eye_y) - OFFSET_W'(word_ff.point_y);
      xc_in    = PROD_W'(dx_ff) * PROD_W'(cos_val);
      ys_in    = PROD_W'(dy_ff) * PROD_W'(sin_val);
      xs_in    = PROD_W'(dx_ff) * PROD_W'(sin_val);
      yc_in    = PROD_W'(dy_ff) * PROD_W'(cos_val);
      rot_x_in = SUM_W'(xc_ff) - SUM_W'(ys_ff);
      rot_y_in = SUM_W'(xs_ff) + SUM_W'(yc_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         word_ff <= in_word;
      end
      if (stage_en[1]) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         clamp2_ff <= word_ff.clamp_request;
      end
      if (stage_en[2]) begin
         xc_ff     <= xc_in;
         ys_ff     <= ys_in;
         xs_ff     <= xs_in;
         yc_ff     <= yc_in;
         clamp3_ff <= clamp2_ff;
      end
      if (stage_en[3]) begin
         rot_x_ff  <= rot_x_in;
         rot_y_ff  <= rot_y_in;
         clamp4_ff <= clamp3_ff;
      end
   end

   assign rot_x         = rot_x_ff;
   assign rot_y         = rot_y_ff;
   assign clamp_request = clamp4_ff;

endmodule
`default_nettype wire

// File: hw/rtl/wtr_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtr_scale: pipeline stages 5 to 8, one lane
// Multiplies by the zoom, then divides by 20000 * 2^15 with rounding:
// bias and shift by 2^20, then divide by 625 through a reciprocal product
// and a one-step correction.
// ----------------------------------------------------------------------------
module wtr_scale
   import wtr_pkg::*;
(
   input  logic                     clock,
   input  logic [3:0]               stage_en,
   input  logic signed [SUM_W-1:0]  rot,
   input  logic [ZOOM_W-1:0]        zoom_milli,
   output logic signed [QUOT_W-1:0] quot
);

   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [SCALED_W-1:0] scaled_in;
   logic [SCALED_W-1:0]        mag;
   logic [SCALED_W:0]          biased;
   logic [SHIFT_W-1:0]         shifted;
   logic [NUM_W-1:0]           num_in;
   logic [NUM_W-1:0]           num6_ff;
   logic                       neg6_ff;
   logic [PRODQ_W-1:0]         recip_prod;
   logic [QE_W-1:0]            qe_in;
   logic [QE_W-1:0]            qe_ff;
   logic [NUM_W-1:0]           num7_ff;
   logic                       neg7_ff;
   logic [NUM_W-1:0]           back;
   logic [NUM_W-1:0]           rem;
   logic [QE_W-1:0]            q_fix;
   logic signed [QUOT_W-1:0]   q_ext;
   logic signed [QUOT_W-1:0]   quot_in;
   logic signed [QUOT_W-1:0]   quot_ff;

   always_comb begin
      scaled_in = SCALED_W'(rot) * SCALED_W'(signed'({1'b0, zoom_milli}));

      mag     = scaled_ff[SCALED_W-1] ? SCALED_W'(-scaled_ff) : SCALED_W'(scaled_ff);
      biased  = (SCALED_W+1)'(mag) + (SCALED_W+1)'(ROUND_HALF);
      shifted = SHIFT_W'(biased >> ROUND_SHIFT);
      // clip large magnitudes, the placement result no longer changes
      if (shifted >= SHIFT_W'(NUM_SAT)) begin
         num_in = NUM_W'(NUM_SAT);
      end else begin
         num_in = shifted[NUM_W-1:0];
      end

      recip_prod = PRODQ_W'(num6_ff) * PRODQ_W'(RECIP);
      qe_in      = recip_prod[RECIP_SHIFT +: QE_W];

      // estimate is low by at most one
      back  = NUM_W'(qe_ff) * NUM_W'(QUOT_DIV);
      rem   = num7_ff - back;
      q_fix = (rem >= NUM_W'(QUOT_DIV)) ? qe_ff + QE_W'(1) : qe_ff;
      q_ext = signed'({1'b0, q_fix});
      quot_in = neg7_ff ? -q_ext : q_ext;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         scaled_ff <= scaled_in;
      end
      if (stage_en[1]) begin
         num6_ff <= num_in;
         neg6_ff <= scaled_ff[SCALED_W-1];
      end
      if (stage_en[2]) begin
         qe_ff   <= qe_in;
         num7_ff <= num6_ff;
         neg7_ff <= neg6_ff;
      end
      if (stage_en[3]) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

// File: hw/rtl/wtr_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtr_place: pipeline stages 9 and 10, one lane
// Adds half the window, clamps to the window edges on request, adds the
// window origin and saturates to the output range.
// ----------------------------------------------------------------------------
module wtr_place
   import wtr_pkg::*;
(
   input  logic                      clock,
   input  logic [1:0]                stage_en,
   input  logic signed [QUOT_W-1:0]  quot,
   input  logic                      clamp_active,
   input  logic [WIN_W-1:0]          win_size,
   input  logic [ORIGIN_HALF_W-1:0]  origin,
   output logic signed [COORD_W-1:0] coord
);

   logic signed [PLACE_W-1:0] half_size;
   logic signed [PLACE_W-1:0] full_size;
   logic signed [PLACE_W-1:0] edge_low;
   logic signed [PLACE_W-1:0] place_in;
   logic signed [PLACE_W-1:0] place_ff;
   logic signed [FINAL_W-1:0] total;
   logic signed [COORD_W-1:0] coord_in;
   logic signed [COORD_W-1:0] coord_ff;

   always_comb begin
      half_size = PLACE_W'({win_size, 3'b000});
      full_size = PLACE_W'({win_size, 4'b0000});
      edge_low  = PLACE_W'(EDGE_LOW_Q4);
      place_in  = PLACE_W'(quot) + half_size;
      // low edge first, then the high edge wins
      if (clamp_active) begin
         if (place_in < edge_low) begin
            place_in = edge_low;
         end
         if (place_in > full_size) begin
            place_in = full_size;
         end
      end

      total = FINAL_W'(place_ff) + FINAL_W'({origin, 4'b0000});
      if (total > FINAL_W'(OUT_MAX)) begin
         coord_in = COORD_W'(OUT_MAX);
      end else if (total < FINAL_W'(OUT_MIN)) begin
         coord_in = COORD_W'(OUT_MIN);
      end else begin
         coord_in = total[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         place_ff <= place_in;
      end
      if (stage_en[1]) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule
`default_nettype wire

// File: hw/rtl/world_to_radar_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_radar_point: maps a world point onto a rotating radar window
// Offset from the eye, rotate by yaw less a quarter turn, scale by zoom,
// center, optionally clamp to the edges, add the window origin, saturate.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one world point per word (Q16.4 x and y, clamp request).
//    A word is taken on an edge with req_valid and req_ready high.
//  - rsp_*: one screen point per request word, in request order, taken on
//    an edge with rsp_valid and rsp_ready high.
//  - csr_*: write-only registers, one write per cycle with csr_write_en.
//    Write them only while no word is in flight.
//  - Order: a taken word passes through the stage registers in turn and
//    shows on rsp_* from the last one; a stall can hold it on the way.
//  - Throughput: one word per cycle while rsp_ready stays high, set by the
//    ten-stage pipeline; every stage holds one word and a valid bit.
//  - Stall: when rsp_ready is low the last stage holds; earlier stages keep
//    advancing into empty slots, so req_ready only drops once all ten
//    stages hold words.
//  - Reset: empties the pipeline and returns the registers to their
//    defaults (eye at origin, yaw 0, zoom 1000, 200x200 window at 0,0,
//    clamping allowed).
// ----------------------------------------------------------------------------
module world_to_radar_point
   import wtr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_word,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_word,
   // register writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic signed [COORD_W-1:0] eye_x_ff;
   logic signed [COORD_W-1:0] eye_y_ff;
   logic [YAW_W-1:0]          view_yaw_ff;
   logic [ZOOM_W-1:0]         zoom_milli_ff;
   logic [WIN_W-1:0]          window_w_ff;
   logic [WIN_W-1:0]          window_h_ff;
   logic [ORIGIN_W-1:0]       window_origin_ff;
   logic                      clamp_enable_ff;

   // pipeline control
   logic [NUM_STAGES-1:0]     valid_ff;
   logic [NUM_STAGES-1:0]     valid_in;
   logic [NUM_STAGES-1:0]     stage_en;

   // clamp request travelling beside the scale stages
   logic [3:0]                clamp_pipe_ff;
   logic                      clamp_rot;
   logic                      clamp_active;

   // datapath links
   sine_type                  sin_val;
   sine_type                  cos_val;
   logic signed [SUM_W-1:0]   rot_x;
   logic signed [SUM_W-1:0]   rot_y;
   logic signed [QUOT_W-1:0]  quot_x;
   logic signed [QUOT_W-1:0]  quot_y;
   logic signed [COORD_W-1:0] screen_x;
   logic signed [COORD_W-1:0] screen_y;

   // -------------------------------------------------------------------------
   // Register writes
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff         <= '0;
         eye_y_ff         <= '0;
         view_yaw_ff      <= '0;
         zoom_milli_ff    <= ZOOM_RESET;
         window_w_ff      <= WIN_RESET;
         window_h_ff      <= WIN_RESET;
         window_origin_ff <= '0;
         clamp_enable_ff  <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_EYE_X:         eye_x_ff         <= csr_wdata[COORD_W-1:0];
            CSR_EYE_Y:         eye_y_ff         <= csr_wdata[COORD_W-1:0];
            CSR_VIEW_YAW:      view_yaw_ff      <= csr_wdata[YAW_W-1:0];
            CSR_ZOOM_MILLI:    zoom_milli_ff    <= csr_wdata[ZOOM_W-1:0];
            CSR_WINDOW_W:      window_w_ff      <= csr_wdata[WIN_W-1:0];
            CSR_WINDOW_H:      window_h_ff      <= csr_wdata[WIN_W-1:0];
            CSR_WINDOW_ORIGIN: window_origin_ff <= csr_wdata[ORIGIN_W-1:0];
            CSR_CLAMP_ENABLE:  clamp_enable_ff  <= csr_wdata[0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stage enables: a stage loads when it is empty or its word moves on.
   // Bubbles are squeezed out, so a stall at the output only reaches the
   // input once every stage is full.
   // -------------------------------------------------------------------------
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // advance the clamp request through stages 5 to 8
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         clamp_pipe_ff[0] <= clamp_rot;
      end
      for (int k = 1; k < 4; k++) begin
         if (stage_en[k+4]) begin
            clamp_pipe_ff[k] <= clamp_pipe_ff[k-1];
         end
      end
   end

   assign clamp_active = clamp_enable_ff && clamp_pipe_ff[3];

   // -------------------------------------------------------------------------
   // Datapath
   // -------------------------------------------------------------------------
   wtr_trig u_trig (
      .clock    (clock),
      .view_yaw (view_yaw_ff),
      .sin_val  (sin_val),
      .cos_val  (cos_val)
   );

   wtr_rotate u_rotate (
      .clock         (clock),
      .stage_en      (stage_en[3:0]),
      .in_word       (req_word),
      .eye_x         (eye_x_ff),
      .eye_y         (eye_y_ff),
      .sin_val       (sin_val),
      .cos_val       (cos_val),
      .rot_x         (rot_x),
      .rot_y         (rot_y),
      .clamp_request (clamp_rot)
   );

   wtr_scale u_scale_x (
      .clock      (clock),
      .stage_en   (stage_en[7:4]),
      .rot        (rot_x),
      .zoom_milli (zoom_milli_ff),
      .quot       (quot_x)
   );

   wtr_scale u_scale_y (
      .clock      (clock),
      .stage_en   (stage_en[7:4]),
      .rot        (rot_y),
      .zoom_milli (zoom_milli_ff),
      .quot       (quot_y)
   );

   wtr_place u_place_x (
      .clock        (clock),
      .stage_en     (stage_en[9:8]),
      .quot         (quot_x),
      .clamp_active (clamp_active),
      .win_size     (window_w_ff),
      .origin       (window_origin_ff[ORIGIN_HALF_W-1:0]),
      .coord        (screen_x)
   );

   wtr_place u_place_y (
      .clock        (clock),
      .stage_en     (stage_en[9:8]),
      .quot         (quot_y),
      .clamp_active (clamp_active),
      .win_size     (window_h_ff),
      .origin       (window_origin_ff[ORIGIN_W-1:ORIGIN_HALF_W]),
      .coord        (screen_y)
   );

   assign req_ready         = stage_en[0];
   assign rsp_valid         = valid_ff[NUM_STAGES-1];
   assign rsp_word.screen_x = screen_x;
   assign rsp_word.screen_y = screen_y;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   // words in flight change only by what enters and leaves
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         $countones(valid_ff) == $past($countones(valid_ff))
            + int'($past(req_valid && req_ready))
            - int'($past(rsp_valid && rsp_ready)))
      else $error("word count in pipeline not conserved");

   // the input only stalls with every stage full and the output blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff) && !rsp_ready)
      else $error("input stalled while pipeline has room");

   // a taken output frees the whole enable chain
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("enable chain broken with output ready");

endmodule
`default_nettype wire

// File: sim/tb_world_to_radar_point.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_world_to_radar_point: self-checking bench for the world-to-radar transform
// Walks a directed table of points and register writes, then runs phases of
// random points under random and extreme register settings. Every screen
// point is checked against a typed value or a bit-exact transform model.
// ----------------------------------------------------------------------------
module tb_world_to_radar_point;
   import wtr_pkg::*;

   localparam int  LIMIT_CYCLES   = 400000;
   localparam int  NUM_PHASES     = 10;
   localparam int  WORDS_PER_PHASE = 115;
   localparam int  MAX_PRINTED    = 100;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint SCALE_DIVISOR = 64'sd20000 << 15;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      csr_index_type        idx;
      logic [CSR_DATA_W-1:0] data;
      logic [COORD_W-1:0]   px;
      logic [COORD_W-1:0]   py;
      logic                 clamp;
      logic                 typed;
      logic [COORD_W-1:0]   ex;
      logic [COORD_W-1:0]   ey;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   rsp_word_type           rsp_word;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Bench copy of the register file
   longint cfg_eye_x, cfg_eye_y, cfg_yaw, cfg_zoom;
   longint cfg_win_w, cfg_win_h, cfg_origin, cfg_clamp_en;

   int           sine_mag [SINE_TABLE_DEPTH+1];
   rsp_word_type screen_q [$];
   stim_row_type dir_rows [$];

   int  mismatch_count = 0;
   int  words_checked  = 0;
   int  clamp_words    = 0;
   int  settings_used  = 1;
   int  cycle_count    = 0;
   bit  quiet          = 1'b0;

   world_to_radar_point uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Transform model
   // ------------------------------------------------------------------------

   // Quarter-wave sine magnitudes: Taylor series in Q2.30, rounded to Q1.15
   function automatic void fill_sine_table();
      longint unsigned x;
      longint unsigned t;
      longint          acc;
      longint          q;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x   = (longint'(k) * PI_HALF_Q30) / SINE_TABLE_DEPTH;
         t   = x;
         acc = longint'(x);
         for (int n = 1; n <= 5; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - longint'(t);
            end else begin
               acc = acc + longint'(t);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         q = (acc + 64'sd16384) >>> 15;
         if (q > 32768) begin
            q = 32768;
         end
         sine_mag[k] = int'(q);
      end
   endfunction

   // Fold the angle into the first quadrant, look up, restore the sign
   function automatic longint sine_lookup(longint unsigned angle);
      longint unsigned full_turn;
      longint unsigned quarter;
      longint unsigned quad;
      longint unsigned frac;
      longint unsigned idx;
      longint          mag;
      full_turn = 64'd1 << ANGLE_BITS;
      quarter   = 64'd1 << (ANGLE_BITS - 2);
      angle     = angle & (full_turn - 1);
      quad      = angle >> (ANGLE_BITS - 2);
      frac      = angle & (quarter - 1);
      if (quad[0]) begin
         frac = quarter - frac;
      end
      idx = (frac * SINE_TABLE_DEPTH) >> (ANGLE_BITS - 2);
      if (idx > SINE_TABLE_DEPTH) begin
         idx = SINE_TABLE_DEPTH;
      end
      mag = sine_mag[idx];
      return (quad >= 2) ? -mag : mag;
   endfunction

   // Divide by 20000 * 2^15, nearest, ties away from zero
   function automatic longint zoom_divide(longint num);
      longint mag;
      longint quot;
      mag  = (num < 0) ? -num : num;
      quot = (mag + SCALE_DIVISOR / 2) / SCALE_DIVISOR;
      return (num < 0) ? -quot : quot;
   endfunction

   function automatic longint saturate_coord(longint v);
      if (v > OUT_MAX) begin
         return OUT_MAX;
      end
      if (v < OUT_MIN) begin
         return OUT_MIN;
      end
      return v;
   endfunction

   function automatic rsp_word_type project_point(req_word_type w);
      longint          dx;
      longint          dy;
      longint          s;
      longint          c;
      longint          sx;
      longint          sy;
      longint unsigned angle;
      rsp_word_type    res;
      dx    = longint'(w.point_x) - cfg_eye_x;
      dy    = cfg_eye_y - longint'(w.point_y);
      angle = ((longint'(cfg_yaw) << 24) >> (40 - ANGLE_BITS))
              - (64'd1 << (ANGLE_BITS - 2));
      s     = sine_lookup(angle);
      c     = sine_lookup(angle + (64'd1 << (ANGLE_BITS - 2)));
      sx    = zoom_divide((dx * c - dy * s) * cfg_zoom) + cfg_win_w * 8;
      sy    = zoom_divide((dx * s + dy * c) * cfg_zoom) + cfg_win_h * 8;
      // low edge first, so a window under 5 pixels ends at its far edge
      if (cfg_clamp_en != 0 && w.clamp_request) begin
         if (sx < EDGE_LOW_Q4) sx = EDGE_LOW_Q4;
         if (sx > cfg_win_w * 16) sx = cfg_win_w * 16;
         if (sy < EDGE_LOW_Q4) sy = EDGE_LOW_Q4;
         if (sy > cfg_win_h * 16) sy = cfg_win_h * 16;
      end
      sx = sx + (cfg_origin & 64'hFFFF) * 16;
      sy = sy + ((cfg_origin >> 16) & 64'hFFFF) * 16;
      res.screen_x = COORD_W'(saturate_coord(sx));
      res.screen_y = COORD_W'(saturate_coord(sy));
      return res;
   endfunction

   function automatic void shadow_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_EYE_X:         cfg_eye_x    = longint'($signed(data[COORD_W-1:0]));
         CSR_EYE_Y:         cfg_eye_y    = longint'($signed(data[COORD_W-1:0]));
         CSR_VIEW_YAW:      cfg_yaw      = longint'(data[YAW_W-1:0]);
         CSR_ZOOM_MILLI:    cfg_zoom     = longint'(data[ZOOM_W-1:0]);
         CSR_WINDOW_W:      cfg_win_w    = longint'(data[WIN_W-1:0]);
         CSR_WINDOW_H:      cfg_win_h    = longint'(data[WIN_W-1:0]);
         CSR_WINDOW_ORIGIN: cfg_origin   = longint'(data);
         CSR_CLAMP_ENABLE:  cfg_clamp_en = longint'(data[0]);
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Drivers: inputs change on the falling edge, outputs sampled on the rising
   // ------------------------------------------------------------------------

   // Offer one word, with an occasional idle burst first; log the expected
   // screen point on the edge that takes it
   task automatic push_word(req_word_type w, bit use_typed, rsp_word_type typed);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do @(posedge clock); while (!req_ready);
      screen_q.push_back(use_typed ? typed : project_point(w));
      if (w.clamp_request) clamp_words++;
   endtask

   // Drop valid and hold until every expected screen point has come back
   task automatic hold_off();
      @(negedge clock);
      req_valid = 1'b0;
      while (screen_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      shadow_write(idx, data);
   endtask

   // Program all registers for one phase; phase 1 sets eye, yaw, zoom, origin
   // to maxima, phase 2 to minima. Upper data bits carry junk the block must drop.
   task automatic pick_setting(int phase);
      logic [CSR_DATA_W-1:0] junk;
      logic [COORD_W-1:0]    ex;
      logic [COORD_W-1:0]    ey;
      logic [YAW_W-1:0]      yaw;
      logic [ZOOM_W-1:0]     zoom;
      logic [WIN_W-1:0]      ww;
      logic [WIN_W-1:0]      wh;
      logic [ORIGIN_W-1:0]   org;
      logic                  cen;
      junk = $urandom;
      if (phase == 1) begin
         ex = 20'h7FFFF; ey = 20'h7FFFF; yaw = '1; zoom = '1;
         ww = 13'd4096; wh = 13'd4096; org = '1; cen = 1'b1;
      end else if (phase == 2) begin
         ex = 20'h80000; ey = 20'h80000; yaw = '0; zoom = '0;
         ww = 13'd1; wh = 13'd1; org = '0; cen = 1'b0;
      end else begin
         case ($urandom_range(0, 3))
            0:       ex = $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
            1:       ex = COORD_W'($urandom);
            default: ex = COORD_W'(int'($urandom_range(0, 40000)) - 20000);
         endcase
         case ($urandom_range(0, 3))
            0:       ey = $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
            1:       ey = COORD_W'($urandom);
            default: ey = COORD_W'(int'($urandom_range(0, 40000)) - 20000);
         endcase
         if ($urandom_range(0, 2) == 0) begin
            yaw = YAW_W'($urandom_range(0, 4) * 16384 - ($urandom_range(0, 1)));
         end else begin
            yaw = YAW_W'($urandom);
         end
         case ($urandom_range(0, 5))
            0:       zoom = '0;
            1:       zoom = '1;
            2:       zoom = ZOOM_W'($urandom);
            3:       zoom = ZOOM_W'(1000);
            default: zoom = ZOOM_W'($urandom_range(1, 20000));
         endcase
         case ($urandom_range(0, 7))
            0:       ww = WIN_W'($urandom_range(0, 5));
            1:       ww = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
            default: ww = WIN_W'($urandom_range(1, 400));
         endcase
         case ($urandom_range(0, 7))
            0:       wh = WIN_W'($urandom_range(0, 5));
            1:       wh = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
            default: wh = WIN_W'($urandom_range(1, 400));
         endcase
         case ($urandom_range(0, 5))
            0:       org = '1;
            1:       org = $urandom;
            2:       org = '0;
            default: org = {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))};
         endcase
         cen = $urandom_range(0, 3) != 0;
      end
      write_reg(CSR_EYE_X,         {junk[31:20], ex});
      write_reg(CSR_EYE_Y,         {junk[19:8], ey});
      write_reg(CSR_VIEW_YAW,      {junk[15:0], yaw});
      write_reg(CSR_ZOOM_MILLI,    {junk[31:16], zoom});
      write_reg(CSR_WINDOW_W,      {junk[18:0], ww});
      write_reg(CSR_WINDOW_H,      {junk[31:13], wh});
      write_reg(CSR_WINDOW_ORIGIN, org);
      write_reg(CSR_CLAMP_ENABLE,  {junk[30:0], cen});
      settings_used++;
   endtask

   // Stall the result side in random bursts, none in the quiet tail
   always begin
      @(negedge clock);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_ready = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      rsp_ready = 1'b1;
   end

   // ------------------------------------------------------------------------
   // Checker
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH @%0t %s: got %0d, want %0d", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_q.size() == 0) begin
            report_mismatch("screen point with none pending", rsp_word.screen_x, 0);
         end else begin
            want = screen_q.pop_front();
            if (rsp_word.screen_x !== want.screen_x) begin
               report_mismatch("screen_x", rsp_word.screen_x, want.screen_x);
            end
            if (rsp_word.screen_y !== want.screen_y) begin
               report_mismatch("screen_y", rsp_word.screen_y, want.screen_y);
            end
            words_checked++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      req_word_type w;
      rsp_word_type typed;
      longint       off;

      cfg_eye_x = 0; cfg_eye_y = 0; cfg_yaw = 0; cfg_zoom = 1000;
      cfg_win_w = 200; cfg_win_h = 200; cfg_origin = 0; cfg_clamp_en = 1;
      fill_sine_table();

      // Directed table, starting from reset defaults (yaw 0: x follows the
      // y offset, y follows the negated x offset, both divided by 20)
      dir_rows = '{
         '{ROW_WORD, CSR_EYE_X, 0, 0, 0, 0, 1, 1600, 1600},
         '{ROW_WORD, CSR_EYE_X, 0, 0, 0, 1, 1, 1600, 1600},
         '{ROW_WORD, CSR_EYE_X, 0, 524287, -524288, 0, 1, 27814, -24614},
         '{ROW_WORD, CSR_EYE_X, 0, 524287, -524288, 1, 1, 3200, 80},
         '{ROW_WORD, CSR_EYE_X, 0, -524288, 524287, 1, 1, 80, 3200},
         '{ROW_WORD, CSR_EYE_X, 0, -524288, 524287, 0, 1, -24614, 27814},
         '{ROW_WORD, CSR_EYE_X, 0, 160, 320, 0, 1, 1584, 1592},
         // a quarter turn of yaw lines the axes up with the world
         '{ROW_CSR, CSR_VIEW_YAW, 16384, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 320, 160, 0, 1, 1616, 1592},
         '{ROW_CSR, CSR_VIEW_YAW, 32768, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 1000, -2000, 1, 0, 0, 0},
         '{ROW_CSR, CSR_VIEW_YAW, 65535, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 12345, -6789, 0, 0, 0, 0},
         // zero zoom collapses every point onto the window center
         '{ROW_CSR, CSR_ZOOM_MILLI, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 524287, 524287, 1, 1, 1600, 1600},
         '{ROW_CSR, CSR_ZOOM_MILLI, 65535, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 524287, -524288, 0, 0, 0, 0},
         // window narrower than the low edge, and a zero-height window
         '{ROW_CSR, CSR_WINDOW_W, 3, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, CSR_WINDOW_H, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 0, 0, 1, 1, 48, 0},
         // origin at the far corner saturates both coordinates
         '{ROW_CSR, CSR_WINDOW_ORIGIN, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 0, 0, 1, 1, 524287, 524287},
         '{ROW_CSR, CSR_WINDOW_ORIGIN, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, CSR_CLAMP_ENABLE, 32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 0, 0, 1, 1, 24, 0},
         '{ROW_CSR, CSR_EYE_X, 32'hFFF8_0000, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, CSR_EYE_Y, 32'h0007_FFFF, 0, 0, 0, 0, 0, 0},
         '{ROW_WORD, CSR_EYE_X, 0, 524287, -524288, 1, 0, 0, 0}
      };

      // Hold reset, then release it on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            hold_off();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
            settings_used++;
         end else begin
            w.point_x       = dir_rows[i].px;
            w.point_y       = dir_rows[i].py;
            w.clamp_request = dir_rows[i].clamp;
            typed.screen_x  = dir_rows[i].ex;
            typed.screen_y  = dir_rows[i].ey;
            push_word(w, dir_rows[i].typed, typed);
         end
      end

      // Random phases: drain, reprogram, then stream points; mostly near the
      // eye so they land around the window, the rest anywhere in the world
      typed = '0;
      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         hold_off();
         pick_setting(phase);
         quiet = (phase == NUM_PHASES);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               w.point_x = COORD_W'($urandom);
               w.point_y = COORD_W'($urandom);
            end else begin
               off = $urandom_range(0, 1) ? 64'sd4000 : 64'sd60000;
               w.point_x = COORD_W'(cfg_eye_x
                  + longint'($urandom_range(0, 32'(2 * off))) - off);
               w.point_y = COORD_W'(cfg_eye_y
                  + longint'($urandom_range(0, 32'(2 * off))) - off);
            end
            w.clamp_request = 1'($urandom_range(0, 1));
            push_word(w, 1'b0, typed);
         end
      end

      // Drain, then give stray words a chance to show up
      hold_off();
      repeat (4 * NUM_STAGES) @(posedge clock);

      $display("Checked %0d screen points (%0d with clamp requests) over %0d register settings.",
               words_checked, clamp_words, settings_used);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
